### hdl/transpose_conv_quant8_defines.svh
// Assertion macros shared by the transposed convolution RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TRANSPOSE_CONV_QUANT8_DEFINES_SVH
`define TRANSPOSE_CONV_QUANT8_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCQ_ASSERT(lbl, prop, msg)
`define TCQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/tcq_pkg.sv
// Geometry, widths, codes and shared types of the transposed convolution block.
// No dependencies.
package tcq_pkg;

    localparam int IN_SIZE   = 8;
    localparam int IN_DEPTH  = 8;
    localparam int OUT_DEPTH = 8;
    localparam int FILT_SIZE = 3;
    localparam int OUT_SIZE  = 16;
    localparam int STRIDE    = 2;

    localparam int N_WEIGHTS = OUT_DEPTH * FILT_SIZE * FILT_SIZE * IN_DEPTH;
    localparam int N_INPUTS  = IN_SIZE * IN_SIZE * IN_DEPTH;
    localparam int N_OUTPUTS = OUT_SIZE * OUT_SIZE * OUT_DEPTH;
    localparam int N_TAPS    = FILT_SIZE * FILT_SIZE * OUT_DEPTH;

    localparam int WA_W = (N_WEIGHTS > 1) ? $clog2(N_WEIGHTS) : 1;
    localparam int BA_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int AA_W = (N_OUTPUTS > 1) ? $clog2(N_OUTPUTS) : 1;
    localparam int D_W  = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int P_W  = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int F_W  = (FILT_SIZE > 1) ? $clog2(FILT_SIZE) : 1;
    localparam int K_W  = BA_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int PA_W = 5;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_INPUT  = 2'd2;
    localparam logic [1:0] CMD_DRAIN  = 2'd3;

    localparam logic [2:0] REG_IN_ZP   = 3'd0;
    localparam logic [2:0] REG_FILT_ZP = 3'd1;
    localparam logic [2:0] REG_OUT_ZP  = 3'd2;
    localparam logic [2:0] REG_MULT    = 3'd3;
    localparam logic [2:0] REG_SHIFT   = 3'd4;
    localparam logic [2:0] REG_ACT_MIN = 3'd5;
    localparam logic [2:0] REG_ACT_MAX = 3'd6;
    localparam logic [2:0] REG_PADDING = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] index;
        logic [31:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  input_zero_point;
        logic [7:0]  filter_zero_point;
        logic [7:0]  output_zero_point;
        logic [30:0] output_multiplier;
        logic [4:0]  output_shift;
        logic [7:0]  activation_min;
        logic [7:0]  activation_max;
        logic [3:0]  padding;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } status_t;

endpackage

### hdl/tcq_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing.
interface tcq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [11:0]        index;
    logic signed [31:0] data_value;

    modport source (output valid, output cmd, output index, output data_value, input ready);
    modport sink   (input valid, input cmd, input index, input data_value, output ready);
endinterface

interface tcq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

### hdl/tcq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module tcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/tcq_front.sv
// Front end: accepts command items, drops out-of-range writes, queues the rest.
// Depends on tcq_pkg, tcq_if and the assertion macros.
`include "transpose_conv_quant8_defines.svh"
module tcq_front (
    input  logic            clk,
    input  logic            rst_n,
    tcq_in_if.sink          in_ch,
    input  tcq_pkg::status_t status,
    output tcq_pkg::item_t  head,
    output logic            head_valid,
    input  logic            pop
);

    tcq_pkg::item_t              q_reg [tcq_pkg::Q_DEPTH];
    logic [tcq_pkg::Q_PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tcq_pkg::Q_PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tcq_pkg::Q_CW-1:0]    count_reg, count_next;
    logic                        accept;
    logic                        keep;
    logic                        push;

    assign in_ch.ready = (count_reg != tcq_pkg::Q_CW'(tcq_pkg::Q_DEPTH)) && !status.clearing;
    assign accept      = in_ch.valid && in_ch.ready;

    // drop writes aimed past the end of a store
    always_comb
    begin
        unique case (in_ch.cmd)
            tcq_pkg::CMD_WEIGHT: keep = (32'(in_ch.index) < 32'(tcq_pkg::N_WEIGHTS));
            tcq_pkg::CMD_BIAS:   keep = (32'(in_ch.index) < 32'(tcq_pkg::OUT_DEPTH));
            default:             keep = 1'b1;
        endcase
    end

    assign push       = accept && keep;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && head_valid)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{cmd: in_ch.cmd, index: in_ch.index,
                                   data: in_ch.data_value};
        end
    end

    `TCQ_ASSERT_ALWAYS(a_queue_bound, count_reg <= tcq_pkg::Q_CW'(tcq_pkg::Q_DEPTH), "queue overfilled")

endmodule

### hdl/tcq_back.sv
// Back end: stores, scatter MAC over the accumulator RAM, requantising drain.
// Depends on tcq_pkg, tcq_if, tcq_ram and the assertion macros.
`include "transpose_conv_quant8_defines.svh"
module tcq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tcq_pkg::cfg_t    cfg,
    input  tcq_pkg::item_t   head,
    input  logic             head_valid,
    output logic             pop,
    output tcq_pkg::status_t status,
    tcq_out_if.source        out_ch
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SCAT  = 4'd2;
    localparam logic [3:0] ST_FLUSH = 4'd3;
    localparam logic [3:0] ST_DR0   = 4'd4;
    localparam logic [3:0] ST_DR1   = 4'd5;
    localparam logic [3:0] ST_DR2   = 4'd6;
    localparam logic [3:0] ST_DR3   = 4'd7;
    localparam logic [3:0] ST_DR4   = 4'd8;
    localparam logic [3:0] ST_DR5   = 4'd9;

    localparam int AA_W = tcq_pkg::AA_W;
    localparam int K_W  = tcq_pkg::K_W;
    localparam int F_W  = tcq_pkg::F_W;
    localparam int D_W  = tcq_pkg::D_W;
    localparam int P_W  = tcq_pkg::P_W;

    logic [3:0]          state_reg, state_next;
    logic [AA_W-1:0]     clr_reg, clr_next;
    logic [F_W-1:0]      i_reg, i_next, j_reg, j_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [D_W-1:0]      pos_d_reg, pos_d_next;
    logic [P_W-1:0]      pos_w_reg, pos_w_next, pos_h_reg, pos_h_next;
    logic signed [15:0]  h0_reg, h0_next, w0_reg, w0_next;
    logic signed [8:0]   xv_reg, xv_next;
    logic                p1_valid_reg, p1_valid_next;
    logic [AA_W-1:0]     p1_addr_reg, p1_addr_next;
    logic [AA_W-1:0]     dp_reg, dp_next;
    logic [K_W-1:0]      dk_reg, dk_next;
    logic [31:0]         v_reg, v_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic [31:0]         hm_reg, hm_next;
    logic [31:0]         rs_reg, rs_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    // RAM ports
    logic                   w_we;
    logic [tcq_pkg::WA_W-1:0] w_waddr, w_raddr;
    logic [7:0]             w_rdata;
    logic                   b_we;
    logic [tcq_pkg::BA_W-1:0] b_waddr;
    logic [31:0]            b_rdata;
    logic                   a_we;
    logic [AA_W-1:0]        a_waddr, a_raddr;
    logic [31:0]            a_wdata, a_rdata;

    // scatter datapath
    logic signed [15:0] ho, wo;
    logic               in_rng;
    logic [31:0]        oi_full, fi_full;
    logic signed [8:0]  fv;
    logic signed [17:0] mac_prod;
    logic               last_tap;

    // drain datapath
    logic [31:0]        mask, rem, thr;
    logic signed [31:0] shq;
    logic signed [31:0] c1, c2, c3, c4;
    logic               out_load;
    logic               drain_last;

    tcq_ram #(.WIDTH(8), .DEPTH(tcq_pkg::N_WEIGHTS)) u_weights (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(head.data[7:0]),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    tcq_ram #(.WIDTH(32), .DEPTH(tcq_pkg::OUT_DEPTH)) u_bias (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(head.data),
        .raddr(dk_reg), .rdata(b_rdata)
    );

    tcq_ram #(.WIDTH(32), .DEPTH(tcq_pkg::N_OUTPUTS)) u_acc (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    assign status.clearing = (state_reg == ST_CLR);
    assign pop             = (state_reg == ST_IDLE) && head_valid;

    assign w_we    = pop && (head.cmd == tcq_pkg::CMD_WEIGHT);
    assign w_waddr = tcq_pkg::WA_W'(head.index);
    assign b_we    = pop && (head.cmd == tcq_pkg::CMD_BIAS);
    assign b_waddr = tcq_pkg::BA_W'(head.index);

    assign ho       = h0_reg + $signed(16'(i_reg));
    assign wo       = w0_reg + $signed(16'(j_reg));
    assign in_rng   = (ho >= 16'sd0) && (ho < $signed(16'(tcq_pkg::OUT_SIZE)))
                   && (wo >= 16'sd0) && (wo < $signed(16'(tcq_pkg::OUT_SIZE)));
    assign oi_full  = 32'((32'(ho) * tcq_pkg::OUT_SIZE + 32'(wo)) * tcq_pkg::OUT_DEPTH
                   + 32'(k_reg));
    assign fi_full  = 32'(((32'(k_reg) * tcq_pkg::FILT_SIZE + 32'(i_reg)) * tcq_pkg::FILT_SIZE
                   + 32'(j_reg)) * tcq_pkg::IN_DEPTH + 32'(pos_d_reg));
    assign w_raddr  = tcq_pkg::WA_W'(fi_full);
    assign a_raddr  = (state_reg == ST_DR0) ? dp_reg : oi_full[AA_W-1:0];
    assign last_tap = (i_reg == F_W'(tcq_pkg::FILT_SIZE - 1))
                   && (j_reg == F_W'(tcq_pkg::FILT_SIZE - 1))
                   && (k_reg == K_W'(tcq_pkg::OUT_DEPTH - 1));

    assign fv       = $signed({1'b0, w_rdata}) - $signed({1'b0, cfg.filter_zero_point});
    assign mac_prod = xv_reg * fv;

    // accumulator write: clearing pass, drained entry, or MAC write-back
    always_comb
    begin
        if (state_reg == ST_CLR)
        begin
            a_we    = 1'b1;
            a_waddr = clr_reg;
            a_wdata = '0;
        end
        else if (state_reg == ST_DR1)
        begin
            a_we    = 1'b1;
            a_waddr = dp_reg;
            a_wdata = '0;
        end
        else
        begin
            a_we    = p1_valid_reg;
            a_waddr = p1_addr_reg;
            a_wdata = a_rdata + 32'(mac_prod);
        end
    end

    // rounding right shift and clamping
    assign mask = (32'h1 << cfg.output_shift) - 32'h1;
    assign rem  = hm_reg & mask;
    assign thr  = (mask >> 1) + {31'b0, hm_reg[31]};
    assign shq  = $signed(hm_reg) >>> cfg.output_shift;
    assign c1   = ($signed(rs_reg) > $signed(32'h7FFF_FF00)) ? $signed(32'h7FFF_FF00)
                                                            : $signed(rs_reg);
    assign c2   = c1 + $signed({24'b0, cfg.output_zero_point});
    assign c3   = (c2 > $signed({24'b0, cfg.activation_max})) ?
                  $signed({24'b0, cfg.activation_max}) : c2;
    assign c4   = (c3 < $signed({24'b0, cfg.activation_min})) ?
                  $signed({24'b0, cfg.activation_min}) : c3;

    assign out_load   = (state_reg == ST_DR5) && (!out_valid_reg || out_ch.ready);
    assign drain_last = (dp_reg == AA_W'(tcq_pkg::N_OUTPUTS - 1));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pos_d_next     = pos_d_reg;
        pos_w_next     = pos_w_reg;
        pos_h_next     = pos_h_reg;
        h0_next        = h0_reg;
        w0_next        = w0_reg;
        xv_next        = xv_reg;
        p1_valid_next  = 1'b0;
        p1_addr_next   = oi_full[AA_W-1:0];
        dp_next        = dp_reg;
        dk_next        = dk_reg;
        v_next         = v_reg;
        prod_next      = prod_reg;
        hm_next        = hm_reg;
        rs_next        = rs_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AA_W'(tcq_pkg::N_OUTPUTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid && head.cmd == tcq_pkg::CMD_INPUT)
                begin
                    xv_next = $signed({1'b0, head.data[7:0]})
                            - $signed({1'b0, cfg.input_zero_point});
                    h0_next = 16'(32'(pos_h_reg) * tcq_pkg::STRIDE) - 16'(cfg.padding);
                    w0_next = 16'(32'(pos_w_reg) * tcq_pkg::STRIDE) - 16'(cfg.padding);
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    state_next = ST_SCAT;
                end
                else if (head_valid && head.cmd == tcq_pkg::CMD_DRAIN)
                begin
                    state_next = ST_DR0;
                end
            end
            ST_SCAT:
            begin
                // one tap per cycle; taps off the output still take their cycle
                p1_valid_next = in_rng;
                if (k_reg == K_W'(tcq_pkg::OUT_DEPTH - 1))
                begin
                    k_next = '0;
                    if (j_reg == F_W'(tcq_pkg::FILT_SIZE - 1))
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
                if (last_tap)
                begin
                    state_next = ST_FLUSH;
                    if (pos_d_reg == D_W'(tcq_pkg::IN_DEPTH - 1))
                    begin
                        pos_d_next = '0;
                        if (pos_w_reg == P_W'(tcq_pkg::IN_SIZE - 1))
                        begin
                            pos_w_next = '0;
                            if (pos_h_reg == P_W'(tcq_pkg::IN_SIZE - 1))
                            begin
                                pos_h_next = '0;
                            end
                            else
                            begin
                                pos_h_next = pos_h_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pos_w_next = pos_w_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pos_d_next = pos_d_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            ST_DR0:
            begin
                state_next = ST_DR1;
            end
            ST_DR1:
            begin
                v_next     = a_rdata + b_rdata;
                state_next = ST_DR2;
            end
            ST_DR2:
            begin
                prod_next  = $signed(v_reg) * $signed({33'b0, cfg.output_multiplier});
                state_next = ST_DR3;
            end
            ST_DR3:
            begin
                // rounding toward zero of (p + nudge) / 2^31 reduces to this
                hm_next    = 32'((prod_reg + 64'sd1073741824) >>> 31);
                state_next = ST_DR4;
            end
            ST_DR4:
            begin
                rs_next    = 32'(shq) + ((rem > thr) ? 32'd1 : 32'd0);
                state_next = ST_DR5;
            end
            ST_DR5:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = c4[7:0];
                    out_last_next  = drain_last;
                    if (drain_last)
                    begin
                        dp_next = '0;
                    end
                    else
                    begin
                        dp_next = dp_reg + 1'b1;
                    end
                    if (dk_reg == K_W'(tcq_pkg::OUT_DEPTH - 1))
                    begin
                        dk_next = '0;
                    end
                    else
                    begin
                        dk_next = dk_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pos_d_reg     <= '0;
            pos_w_reg     <= '0;
            pos_h_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            dp_reg        <= '0;
            dk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            pos_d_reg     <= pos_d_next;
            pos_w_reg     <= pos_w_next;
            pos_h_reg     <= pos_h_next;
            p1_valid_reg  <= p1_valid_next;
            dp_reg        <= dp_next;
            dk_reg        <= dk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg        <= h0_next;
        w0_reg        <= w0_next;
        xv_reg        <= xv_next;
        p1_addr_reg   <= p1_addr_next;
        v_reg         <= v_next;
        prod_reg      <= prod_next;
        hm_reg        <= hm_next;
        rs_reg        <= rs_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.out_last  = out_last_reg;

    `TCQ_ASSERT(a_clr_no_mac, (state_reg == ST_CLR) |-> !p1_valid_reg && !out_valid_reg, "MAC or result during clearing pass")
    `TCQ_ASSERT(a_mac_after_scatter, p1_valid_reg |-> ($past(state_reg) == ST_SCAT), "write-back outside scatter")
    `TCQ_ASSERT(a_result_loaded, (state_reg == ST_DR5 && !out_valid_reg) |=> out_valid_reg, "drain result not loaded")

endmodule

### hdl/transpose_conv_quant8.sv
// Top level of the uint8 transposed convolution block: APB registers, front and back.
// Depends on tcq_pkg, tcq_if, tcq_front and tcq_back.
//
// Usage. Command items arrive on in_ch (valid/ready): weight writes, bias writes,
// input elements in height, width, depth order, and drain requests. Results leave
// on out_ch (valid/ready), one per drain, in height, width, channel order, with
// out_last on the final element of the image. Registers sit on the APB port at
// byte address 4*index; write them only while the block is idle.
//
// Timing. A four-entry queue decouples acceptance from execution. The back end takes
// weight and bias writes straight into their RAMs. An input element is scattered at one
// MAC per cycle, set by the single read and write port of the accumulator RAM. A drain
// passes through the requantising pipeline (add bias, multiply, round, shift, clamp).
//
// Reset clears all control state, then a clearing pass over all N_OUTPUTS entries (2048 at
// the default geometry) zeroes the accumulator RAM; no item is accepted during it.
// When the receiver stalls, the result is held in the output register and the back
// end carries on with non-drain items; the next drain waits for the register.
module transpose_conv_quant8 (
    input  logic                      clk,
    input  logic                      rst_n,
    tcq_in_if.sink                    in_ch,
    tcq_out_if.source                 out_ch,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tcq_pkg::PA_W-1:0]  paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    tcq_pkg::cfg_t    cfg_reg;
    tcq_pkg::item_t   head;
    tcq_pkg::status_t status;
    logic             head_valid;
    logic             pop;
    logic             cfg_wr;
    logic [2:0]       reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];

    // register file: hold until written, mask each value to its field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_zero_point  <= 8'd0;
            cfg_reg.filter_zero_point <= 8'd0;
            cfg_reg.output_zero_point <= 8'd0;
            cfg_reg.output_multiplier <= 31'd1073741824;
            cfg_reg.output_shift      <= 5'd0;
            cfg_reg.activation_min    <= 8'd0;
            cfg_reg.activation_max    <= 8'd255;
            cfg_reg.padding           <= 4'd0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                tcq_pkg::REG_IN_ZP:   cfg_reg.input_zero_point  <= pwdata[7:0];
                tcq_pkg::REG_FILT_ZP: cfg_reg.filter_zero_point <= pwdata[7:0];
                tcq_pkg::REG_OUT_ZP:  cfg_reg.output_zero_point <= pwdata[7:0];
                tcq_pkg::REG_MULT:    cfg_reg.output_multiplier <= pwdata[30:0];
                tcq_pkg::REG_SHIFT:   cfg_reg.output_shift      <= pwdata[4:0];
                tcq_pkg::REG_ACT_MIN: cfg_reg.activation_min    <= pwdata[7:0];
                tcq_pkg::REG_ACT_MAX: cfg_reg.activation_max    <= pwdata[7:0];
                tcq_pkg::REG_PADDING: cfg_reg.padding           <= pwdata[3:0];
                default:              cfg_reg.padding           <= cfg_reg.padding;
            endcase
        end
    end

    // read back, zero-extended
    always_comb
    begin
        unique case (reg_sel)
            tcq_pkg::REG_IN_ZP:   prdata = {24'b0, cfg_reg.input_zero_point};
            tcq_pkg::REG_FILT_ZP: prdata = {24'b0, cfg_reg.filter_zero_point};
            tcq_pkg::REG_OUT_ZP:  prdata = {24'b0, cfg_reg.output_zero_point};
            tcq_pkg::REG_MULT:    prdata = {1'b0, cfg_reg.output_multiplier};
            tcq_pkg::REG_SHIFT:   prdata = {27'b0, cfg_reg.output_shift};
            tcq_pkg::REG_ACT_MIN: prdata = {24'b0, cfg_reg.activation_min};
            tcq_pkg::REG_ACT_MAX: prdata = {24'b0, cfg_reg.activation_max};
            tcq_pkg::REG_PADDING: prdata = {28'b0, cfg_reg.padding};
            default:              prdata = '0;
        endcase
    end

    // accept, classify and queue
    tcq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .status     (status),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // execute: stores, scatter MAC, drain and output register
    tcq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .status     (status),
        .out_ch     (out_ch)
    );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for transpose_conv_quant8: drives command items, predicts results.
// Depends on tcq_pkg, tcq_if and transpose_conv_quant8 from the RTL; uses the APB port for register writes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcq_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    // Longest back-end occupancy: full command queue of input elements plus the drain pipe.
    localparam int SETTLE_CYCLES = (Q_DEPTH + 1) * (N_TAPS + 2) + 40;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } conv_out_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] index;
        logic [31:0] data;
        bit          typed;
        logic [7:0]  value;
        logic        last;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PA_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tcq_in_if  in_ch ();
    tcq_out_if out_ch ();

    transpose_conv_quant8 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's state and registers.
    logic [7:0]  shadow_weights [N_WEIGHTS];
    logic [31:0] shadow_bias [OUT_DEPTH];
    logic [31:0] shadow_acc [N_OUTPUTS];
    int          in_pos;
    int          drain_pos;
    cfg_t        shadow_cfg;

    conv_out_t pending_outputs[$];
    int        errors;
    int        cycle_count;
    int        burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Record one mismatch on a single line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    function automatic void reset_shadow();
        shadow_cfg = '{input_zero_point: 8'd0, filter_zero_point: 8'd0,
                       output_zero_point: 8'd0, output_multiplier: 31'h40000000,
                       output_shift: 5'd0, activation_min: 8'd0,
                       activation_max: 8'd255, padding: 4'd0};
        foreach (shadow_acc[n]) shadow_acc[n] = '0;
        foreach (shadow_weights[n]) shadow_weights[n] = '0;
        foreach (shadow_bias[n]) shadow_bias[n] = '0;
        in_pos = 0;
        drain_pos = 0;
    endfunction

    // Scatter one input element over every in-range filter tap into the accumulator shadow.
    function automatic void scatter_element(input logic [7:0] element);
        int d, w, h, h0, w0, xv, fv, ho, wo, fi, oi;
        d  = in_pos % IN_DEPTH;
        w  = (in_pos / IN_DEPTH) % IN_SIZE;
        h  = in_pos / (IN_DEPTH * IN_SIZE);
        h0 = h * STRIDE - int'(shadow_cfg.padding);
        w0 = w * STRIDE - int'(shadow_cfg.padding);
        xv = int'(element) - int'(shadow_cfg.input_zero_point);
        for (int i = 0; i < FILT_SIZE; i++)
        begin
            for (int j = 0; j < FILT_SIZE; j++)
            begin
                ho = h0 + i;
                wo = w0 + j;
                if (ho < 0 || ho >= OUT_SIZE || wo < 0 || wo >= OUT_SIZE)
                    continue;
                for (int k = 0; k < OUT_DEPTH; k++)
                begin
                    fi = ((k * FILT_SIZE + i) * FILT_SIZE + j) * IN_DEPTH + d;
                    oi = (ho * OUT_SIZE + wo) * OUT_DEPTH + k;
                    fv = int'(shadow_weights[fi]) - int'(shadow_cfg.filter_zero_point);
                    shadow_acc[oi] = shadow_acc[oi] + 32'(xv * fv);
                end
            end
        end
        in_pos = (in_pos + 1 >= N_INPUTS) ? 0 : in_pos + 1;
    endfunction

    // Requantise and clear the next accumulator in drain order.
    function automatic conv_out_t drain_output();
        conv_out_t res;
        logic signed [31:0] v, q;
        logic [31:0] mask, rem, thr;
        longint prod, nudge;
        int k;
        k = drain_pos % OUT_DEPTH;
        v = shadow_acc[drain_pos] + shadow_bias[k];
        prod  = longint'(v) * longint'({1'b0, shadow_cfg.output_multiplier});
        nudge = (prod >= 0) ? 64'sd1073741824 : 64'sd1 - 64'sd1073741824;
        v = 32'((prod + nudge) / 64'sd2147483648);
        mask = (32'd1 << shadow_cfg.output_shift) - 32'd1;
        rem  = v & mask;
        thr  = (mask >> 1) + ((v < 0) ? 32'd1 : 32'd0);
        q = v >>> shadow_cfg.output_shift;
        v = q + ((rem > thr) ? 32'sd1 : 32'sd0);
        if (v > 32'sd2147483647 - 32'sd255)
            v = 32'sd2147483647 - 32'sd255;
        v = v + $signed({24'd0, shadow_cfg.output_zero_point});
        if (v > $signed({24'd0, shadow_cfg.activation_max}))
            v = $signed({24'd0, shadow_cfg.activation_max});
        if (v < $signed({24'd0, shadow_cfg.activation_min}))
            v = $signed({24'd0, shadow_cfg.activation_min});
        res.value = v[7:0];
        res.last  = (drain_pos + 1 >= N_OUTPUTS);
        shadow_acc[drain_pos] = '0;
        drain_pos = res.last ? 0 : drain_pos + 1;
        return res;
    endfunction

    // Apply one accepted item to the shadow; return 1 when it yields a result.
    function automatic bit apply_item(input logic [1:0] cmd, input logic [11:0] index,
                                      input logic [31:0] data, output conv_out_t res);
        res = '0;
        case (cmd)
            CMD_WEIGHT: if (index < N_WEIGHTS) shadow_weights[index] = data[7:0];
            CMD_BIAS:   if (index < OUT_DEPTH) shadow_bias[index] = data;
            CMD_INPUT:  scatter_element(data[7:0]);
            default:
            begin
                res = drain_output();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Offer one item, honouring the burst/gap pattern, and hold it until accepted.
    task automatic send_item(input logic [1:0] cmd, input logic [11:0] index,
                             input logic [31:0] data, input bit typed = 1'b0,
                             input logic [7:0] tvalue = '0, input logic tlast = 1'b0);
        conv_out_t res;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.index      <= index;
        in_ch.data_value <= data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
        if (apply_item(cmd, index, data, res))
        begin
            if (typed)
            begin
                res.value = tvalue;
                res.last  = tlast;
            end
            pending_outputs.push_back(res);
        end
    endtask

    // Drop valid and let the block drain before a register change.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic reg_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input cfg_t c);
        reg_write(REG_IN_ZP,   {24'd0, c.input_zero_point});
        reg_write(REG_FILT_ZP, {24'd0, c.filter_zero_point});
        reg_write(REG_OUT_ZP,  {24'd0, c.output_zero_point});
        reg_write(REG_MULT,    {1'b0, c.output_multiplier});
        reg_write(REG_SHIFT,   {27'd0, c.output_shift});
        reg_write(REG_ACT_MIN, {24'd0, c.activation_min});
        reg_write(REG_ACT_MAX, {24'd0, c.activation_max});
        reg_write(REG_PADDING, {28'd0, c.padding});
        shadow_cfg = c;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.input_zero_point  = 8'($urandom);
        c.filter_zero_point = 8'($urandom);
        c.output_zero_point = 8'($urandom_range(0, 64));
        c.output_multiplier = 31'($urandom);
        c.output_shift      = 5'($urandom_range(0, 12));
        c.activation_min    = 8'($urandom_range(0, 40));
        c.activation_max    = 8'($urandom_range(200, 255));
        c.padding           = 4'($urandom);
        return c;
    endfunction

    // Mostly input elements and drains, with some weight and bias rewrites mixed in.
    task automatic send_random_item();
        int pick;
        logic [11:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, N_WEIGHTS - 1));
            send_item(CMD_WEIGHT, idx, $urandom);
        end
        else if (pick < 13)
        begin
            idx = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, OUT_DEPTH - 1));
            send_item(CMD_BIAS, idx, $urandom);
        end
        else if (pick < 60)
            send_item(CMD_INPUT, 12'($urandom), $urandom);
        else
            send_item(CMD_DRAIN, 12'($urandom), $urandom);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        int mode;
        conv_out_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_outputs.size() == 0)
                    report_mismatch("unexpected result, out_value", out_ch.out_value, -1);
                else
                begin
                    want = pending_outputs.pop_front();
                    if (out_ch.out_value !== want.value)
                        report_mismatch("out_value", out_ch.out_value, want.value);
                    if (out_ch.out_last !== want.last)
                        report_mismatch("out_last", out_ch.out_last, want.last);
                end
            end
            // Rotate through free-running, random, long-stall and light-stall stretches.
            mode = (cycle_count >> 7) % 4;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= (cycle_count % 32) < 8;
                default: out_ch.ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    initial
    begin
        stim_row_t rows [$];
        cfg_t phases [$];
        cfg_t c;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WEIGHT;
        in_ch.index = '0;
        in_ch.data_value = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        cycle_count = 0;
        burst_left = 0;
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every weight and bias first so nothing unwritten is ever read.
        for (int n = 0; n < N_WEIGHTS; n++)
            send_item(CMD_WEIGHT, 12'(n), $urandom);
        for (int n = 0; n < OUT_DEPTH; n++)
            send_item(CMD_BIAS, 12'(n), $urandom_range(0, 4000) - 2000);

        // Directed: ignored writes, bias extremes, input byte extremes, early drains.
        rows.push_back('{CMD_WEIGHT, 12'd4095, 32'hFFFFFFFF, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_WEIGHT, 12'(N_WEIGHTS), 32'h0, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_BIAS, 12'(OUT_DEPTH), 32'h7FFFFFFF, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_BIAS, 12'd4095, 32'h80000000, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_BIAS, 12'd0, 32'h7FFFFFFF, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_BIAS, 12'd1, 32'h80000000, 1'b0, 8'd0, 1'b0});
        // Drain before any input: empty accumulator plus extreme bias saturates.
        rows.push_back('{CMD_DRAIN, 12'd0, 32'h0, 1'b1, 8'd255, 1'b0});
        rows.push_back('{CMD_DRAIN, 12'd4095, 32'hFFFFFFFF, 1'b1, 8'd0, 1'b0});
        rows.push_back('{CMD_WEIGHT, 12'd0, 32'hFFFFFF00, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_WEIGHT, 12'(N_WEIGHTS - 1), 32'h000000FF, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_BIAS, 12'd2, 32'h0, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_INPUT, 12'd0, 32'h00000000, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_INPUT, 12'd4095, 32'h000000FF, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_INPUT, 12'hAAA, 32'hABCDEF7F, 1'b0, 8'd0, 1'b0});
        rows.push_back('{CMD_INPUT, 12'h555, 32'h80000000, 1'b0, 8'd0, 1'b0});
        for (int n = 0; n < 4; n++)
            rows.push_back('{CMD_DRAIN, 12'd0, 32'h0, 1'b0, 8'd0, 1'b0});
        foreach (rows[n])
            send_item(rows[n].cmd, rows[n].index, rows[n].data,
                      rows[n].typed, rows[n].value, rows[n].last);

        // Register settings: a usable one, all extremes (clamp bounds crossed), all zero, random.
        phases.push_back('{8'd128, 8'd128, 8'd10, 31'h40000000, 5'd8, 8'd0, 8'd255, 4'd1});
        phases.push_back('{8'd255, 8'd255, 8'd255, 31'h7FFFFFFF, 5'd31, 8'd255, 8'd0, 4'd15});
        phases.push_back('{8'd0, 8'd0, 8'd0, 31'd0, 5'd0, 8'd0, 8'd0, 4'd0});
        for (int n = 0; n < 3; n++)
            phases.push_back(random_config());
        foreach (phases[p])
        begin
            settle();
            load_config(phases[p]);
            repeat (120) send_random_item();
        end

        // Full image: run in_pos and drain_pos round their wrap points.
        settle();
        c = '{8'd100, 8'd120, 8'd5, 31'h50000000, 5'd10, 8'd3, 8'd250, 4'd2};
        load_config(c);
        while (in_pos != 0) send_item(CMD_INPUT, 12'($urandom), $urandom);
        repeat (N_INPUTS + 3) send_item(CMD_INPUT, 12'($urandom), $urandom);
        while (drain_pos != 0) send_item(CMD_DRAIN, 12'($urandom), $urandom);
        repeat (N_OUTPUTS + 3) send_item(CMD_DRAIN, 12'($urandom), $urandom);

        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/tcq_pkg.sv
hdl/tcq_if.sv
hdl/tcq_ram.sv
hdl/tcq_front.sv
hdl/tcq_back.sv
hdl/transpose_conv_quant8.sv
tb/sv/testbench.sv
